>>> design/sps_pkg.sv
// Shared types and constants for the sine PWM soft ramp generator.
package sps_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 128;
    localparam int unsigned DUTY_W          = 16;
    localparam int unsigned ENV_W           = 17;
    localparam int unsigned PHASE_W         = 7;
    localparam int unsigned PERIOD_W        = 8;
    localparam int unsigned CFG_W           = 17;
    localparam int unsigned CFG_INDEX_W     = 1;

    localparam logic [ENV_W-1:0]    ENV_ONE           = ENV_W'(65536);
    localparam logic [ENV_W-1:0]    RAMP_STEP_RESET   = ENV_W'(66);
    localparam logic [PERIOD_W-1:0] PERIOD_LEN_RESET  = PERIOD_W'(100);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RAMP_STEP     = 1'b0,
        REG_PERIOD_LENGTH = 1'b1
    } cfg_reg_t;

    // Control and envelope that travel with an item into the scaling stage.
    typedef struct packed {
        logic             valid;
        logic             duty_en;
        logic             bridge_on;
        logic             stopped;
        logic [ENV_W-1:0] envelope;
    } stage_t;

endpackage

>>> design/sps_table.sv
// Wave table memory with one write port and one registered read port.
module sps_table import sps_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DUTY_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DUTY_W-1:0] rd_data
);

    logic [DUTY_W-1:0] mem [TABLE_DEPTH];
    logic [DUTY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sps_ctrl.sv
// Configuration registers, envelope and phase state, and the first pipeline stage.
module sps_ctrl import sps_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   load,
    input  logic                   accept,
    input  logic [1:0]             operation,
    input  logic [PHASE_W-1:0]     entry_index,
    input  logic [DUTY_W-1:0]      entry_value,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [DUTY_W-1:0]      wr_data,
    output logic                   rd_en,
    output logic [ADDR_W-1:0]      rd_addr,
    output stage_t                 stage
);

    localparam int unsigned LAST_ADDR = TABLE_DEPTH - 1;

    logic [ENV_W-1:0]    ramp_step_reg;
    logic [PERIOD_W-1:0] period_len_reg;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ENV_W-1:0]    env_reg, env_next;
    logic                down_reg, down_next;
    logic                running_reg, running_next;
    stage_t              stage_reg, stage_next;

    logic [ENV_W:0]      env_sum;
    logic [PERIOD_W-1:0] phase_inc;
    logic                at_zero;
    op_t                 op;

    // Reduces a table position modulo the depth by conditional subtraction.
    function automatic logic [ADDR_W-1:0] wrap_index(input logic [PHASE_W-1:0] idx);
        int unsigned v;
        v = 32'(idx);
        for (int k = PHASE_W - 1; k >= 0; k--) begin
            if (v >= (TABLE_DEPTH << k)) begin
                v = v - (TABLE_DEPTH << k);
            end
        end
        return ADDR_W'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg  <= RAMP_STEP_RESET;
            period_len_reg <= PERIOD_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RAMP_STEP:     ramp_step_reg  <= cfg_wdata;
                REG_PERIOD_LENGTH: period_len_reg <= cfg_wdata[PERIOD_W-1:0];
                default:           ramp_step_reg  <= ramp_step_reg;
            endcase
        end
    end

    assign op        = op_t'(operation);
    assign env_sum   = {1'b0, env_reg} + {1'b0, ramp_step_reg};
    assign phase_inc = {1'b0, phase_reg} + PERIOD_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        env_next     = env_reg;
        down_next    = down_reg;
        running_next = running_reg;
        at_zero      = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        stage_next   = '0;
        unique case (op)
            OP_START: begin
                phase_next   = '0;
                addr_next    = '0;
                env_next     = '0;
                down_next    = 1'b0;
                running_next = 1'b1;
            end
            OP_STOP: begin
                down_next = 1'b1;
            end
            OP_WRITE: begin
                wr_en = accept;
            end
            OP_TICK: begin
                if (running_reg) begin
                    if (down_reg) begin
                        if (ramp_step_reg >= env_reg) begin
                            env_next = '0;
                            at_zero  = 1'b1;
                        end else begin
                            env_next = env_reg - ramp_step_reg;
                        end
                    end else if (env_sum >= {1'b0, ENV_ONE}) begin
                        env_next = ENV_ONE;
                    end else begin
                        env_next = env_sum[ENV_W-1:0];
                        at_zero  = (env_sum == '0);
                    end
                    if (at_zero) begin
                        running_next = 1'b0;
                    end else begin
                        rd_en = accept;
                        stage_next.duty_en = 1'b1;
                        if ((phase_inc >= period_len_reg) || phase_inc[PHASE_W]) begin
                            phase_next = '0;
                            addr_next  = '0;
                        end else begin
                            phase_next = phase_inc[PHASE_W-1:0];
                            addr_next  = (32'(addr_reg) == LAST_ADDR) ? '0
                                         : addr_reg + ADDR_W'(1);
                        end
                    end
                end
            end
            default: begin
                running_next = running_reg;
            end
        endcase
        stage_next.valid     = accept;
        stage_next.stopped   = at_zero;
        stage_next.bridge_on = running_next;
        stage_next.envelope  = env_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            addr_reg    <= '0;
            env_reg     <= '0;
            down_reg    <= 1'b0;
            running_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            env_reg     <= env_next;
            down_reg    <= down_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign wr_addr = wrap_index(entry_index);
    assign wr_data = entry_value;
    assign rd_addr = addr_reg;
    assign stage   = stage_reg;

endmodule

>>> design/sps_scale.sv
// Envelope scaling of the table entry and the result register.
module sps_scale import sps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  stage_t            stage,
    input  logic [DUTY_W-1:0] entry,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DUTY_W-1:0] m_duty,
    output logic              m_bridge_on,
    output logic              m_stopped_now
);

    logic [DUTY_W+ENV_W-1:0] product;
    logic                    valid_reg;
    logic [DUTY_W-1:0]       duty_reg;
    logic                    bridge_reg;
    logic                    stopped_reg;

    assign advance = !valid_reg || m_ready;
    assign product = (DUTY_W+ENV_W)'(entry) * (DUTY_W+ENV_W)'(stage.envelope);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage.valid) begin
            duty_reg    <= stage.duty_en ? product[DUTY_W+15:16] : '0;
            bridge_reg  <= stage.bridge_on;
            stopped_reg <= stage.stopped;
        end
    end

    assign m_valid       = valid_reg;
    assign m_duty        = duty_reg;
    assign m_bridge_on   = bridge_reg;
    assign m_stopped_now = stopped_reg;

endmodule

>>> design/sine_pwm_soft_ramp.sv
// Top level of the sine PWM duty generator with soft start and soft stop.
// Each item (tick, start, stop or table write) gives one result item via the stage and result
// registers; a new item is accepted in every cycle while results are taken. The first stage
// updates the envelope and phase index and reads the wave table through its registered port;
// the second stage scales the entry by the envelope in a 16 by 17 bit multiplier.
module sine_pwm_soft_ramp import sps_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_operation,
    input  logic [PHASE_W-1:0]     s_entry_index,
    input  logic [DUTY_W-1:0]      s_entry_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DUTY_W-1:0]      m_duty,
    output logic                   m_bridge_on,
    output logic                   m_stopped_now
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    stage_t            stage;
    logic              advance;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DUTY_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DUTY_W-1:0] rd_data;

    assign s_ready = advance || !stage.valid;
    assign accept  = s_valid && s_ready;

    sps_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .load        (s_ready),
        .accept      (accept),
        .operation   (s_operation),
        .entry_index (s_entry_index),
        .entry_value (s_entry_value),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .stage       (stage)
    );

    sps_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sps_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage         (stage),
        .entry         (rd_data),
        .advance       (advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_bridge_on   (m_bridge_on),
        .m_stopped_now (m_stopped_now)
    );

endmodule
